FILE: hdl/lcvm_pkg.sv
// Shared types, register indexes and codes for the line clip and viewport map block.
// No dependencies; the files that use it refer to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package lcvm_pkg;

	localparam int CoordW  = 16;
	localparam int DiffW   = 17;
	localparam int CfgIdxW = 4;

	localparam logic [CfgIdxW-1:0] REG_WIN_X_MIN  = 4'd0;
	localparam logic [CfgIdxW-1:0] REG_WIN_Y_MIN  = 4'd1;
	localparam logic [CfgIdxW-1:0] REG_WIN_X_MAX  = 4'd2;
	localparam logic [CfgIdxW-1:0] REG_WIN_Y_MAX  = 4'd3;
	localparam logic [CfgIdxW-1:0] REG_VIEW_X_MIN = 4'd4;
	localparam logic [CfgIdxW-1:0] REG_VIEW_Y_MIN = 4'd5;
	localparam logic [CfgIdxW-1:0] REG_VIEW_X_MAX = 4'd6;
	localparam logic [CfgIdxW-1:0] REG_VIEW_Y_MAX = 4'd7;

	localparam logic [CoordW-1:0] RST_WIN_MIN  = 16'd50;
	localparam logic [CoordW-1:0] RST_WIN_MAX  = 16'd100;
	localparam logic [CoordW-1:0] RST_VIEW_MIN = 16'd200;
	localparam logic [CoordW-1:0] RST_VIEW_MAX = 16'd300;

	// edge classes of the parametric test
	localparam logic [1:0] EK_NONE   = 2'd0;
	localparam logic [1:0] EK_ENTER  = 2'd1;
	localparam logic [1:0] EK_LEAVE  = 2'd2;
	localparam logic [1:0] EK_REJECT = 2'd3;

	typedef struct packed {
		logic signed [CoordW-1:0] win_x_min;
		logic signed [CoordW-1:0] win_y_min;
		logic signed [CoordW-1:0] win_x_max;
		logic signed [CoordW-1:0] win_y_max;
		logic signed [CoordW-1:0] view_x_min;
		logic signed [CoordW-1:0] view_y_min;
		logic signed [CoordW-1:0] view_x_max;
		logic signed [CoordW-1:0] view_y_max;
	} cfg_t;

	function automatic logic signed [DiffW-1:0] sub17(input logic signed [CoordW-1:0] a,
		input logic signed [CoordW-1:0] b);
		return $signed({a[CoordW-1], a}) - $signed({b[CoordW-1], b});
	endfunction

endpackage

`default_nettype wire

FILE: hdl/line_clip_viewport_map.sv
// Top level of the line clip and viewport map block: config registers and the
// front end, queue and back end. Depends on lcvm_pkg, lcvm_front, lcvm_queue, lcvm_back.
`timescale 1ns / 1ps
`default_nettype none

// Clips each segment against the window by the parametric edge test and maps the
// clipped endpoints into the viewport, rounded to nearest and saturated to 16 bits.
// One segment is taken and one result given every cycle while no side stalls. The
// front end holds the per-edge quotient pipeline and the back end the rounding divider.
// A four-word queue sits between the two so either side may stall alone.
// Rejected segments come out with visible clear and all coordinates zero.

module line_clip_viewport_map #(
	parameter int FRACTION_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // start_x, start_y, end_x, end_y
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,   // out_start_x, out_start_y, out_end_x, out_end_y
	output logic        m_axis_tuser,   // visible
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int ItemW  = 1 + 2 * 16 + 2 * 17 + 2 * (FRACTION_BITS + 1);
	localparam int QDepth = 4;

	lcvm_pkg::cfg_t   cfg_q;
	logic             push, full, pop, empty;
	logic [ItemW-1:0] push_data, pop_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.win_x_min  <= lcvm_pkg::RST_WIN_MIN;
			cfg_q.win_y_min  <= lcvm_pkg::RST_WIN_MIN;
			cfg_q.win_x_max  <= lcvm_pkg::RST_WIN_MAX;
			cfg_q.win_y_max  <= lcvm_pkg::RST_WIN_MAX;
			cfg_q.view_x_min <= lcvm_pkg::RST_VIEW_MIN;
			cfg_q.view_y_min <= lcvm_pkg::RST_VIEW_MIN;
			cfg_q.view_x_max <= lcvm_pkg::RST_VIEW_MAX;
			cfg_q.view_y_max <= lcvm_pkg::RST_VIEW_MAX;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				lcvm_pkg::REG_WIN_X_MIN:  cfg_q.win_x_min  <= cfg_data;
				lcvm_pkg::REG_WIN_Y_MIN:  cfg_q.win_y_min  <= cfg_data;
				lcvm_pkg::REG_WIN_X_MAX:  cfg_q.win_x_max  <= cfg_data;
				lcvm_pkg::REG_WIN_Y_MAX:  cfg_q.win_y_max  <= cfg_data;
				lcvm_pkg::REG_VIEW_X_MIN: cfg_q.view_x_min <= cfg_data;
				lcvm_pkg::REG_VIEW_Y_MIN: cfg_q.view_y_min <= cfg_data;
				lcvm_pkg::REG_VIEW_X_MAX: cfg_q.view_x_max <= cfg_data;
				lcvm_pkg::REG_VIEW_Y_MAX: cfg_q.view_y_max <= cfg_data;
				default: ;
			endcase
		end
	end

	lcvm_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_data   (s_axis_tdata),
		.push      (push),
		.full      (full),
		.push_data (push_data)
	);

	lcvm_queue #(.WIDTH(ItemW), .DEPTH(QDepth)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	lcvm_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.empty     (empty),
		.pop       (pop),
		.pop_data  (pop_data),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_vis   (m_axis_tuser),
		.out_data  (m_axis_tdata)
	);

endmodule

`default_nettype wire

FILE: hdl/lcvm_queue.sv
// Small register queue between the clip front end and the mapping back end.
// Depends on nothing; width and depth come from the instance.
`timescale 1ns / 1ps
`default_nettype none

module lcvm_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PtrW-1:0]  wr_q;
	logic [PtrW-1:0]  rd_q;
	logic [CntW-1:0]  cnt_q;

	assign full     = (cnt_q == CntW'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) full |-> !push)
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) empty |-> !pop)
		else $error("queue read while empty");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
		else $error("queue count lost a word");

endmodule

`default_nettype wire

FILE: hdl/lcvm_front.sv
// Clip front end: edge classification, pipelined per-edge divisions, entry/exit reduction.
// Depends on lcvm_pkg; feeds lcvm_queue.
`timescale 1ns / 1ps
`default_nettype none

module lcvm_front #(
	parameter int FRACTION_BITS = 16,
	localparam int ItemW = 1 + 2 * 16 + 2 * 17 + 2 * (FRACTION_BITS + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  lcvm_pkg::cfg_t    cfg,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [63:0]       in_data,
	output logic              push,
	input  logic              full,
	output logic [ItemW-1:0]  push_data
);

	localparam int F  = FRACTION_BITS;
	localparam int NS = F + 1;
	localparam int TW = F + 2;
	localparam logic [TW-1:0] TSAT = {2'b10, {F{1'b0}}};
	localparam logic [TW-1:0] TONE = {2'b01, {F{1'b0}}};

	typedef struct packed {
		logic [16:0] num;
		logic [16:0] den;
		logic [1:0]  kind;
	} bnd_t;

	function automatic bnd_t classify(input logic signed [16:0] p, input logic signed [16:0] q);
		bnd_t b;
		b.num = q[16] ? 17'(-q) : q;
		b.den = p[16] ? 17'(-p) : p;
		if (p == '0) begin
			b.kind = q[16] ? lcvm_pkg::EK_REJECT : lcvm_pkg::EK_NONE;
		end else if (p[16]) begin
			b.kind = q[16] ? lcvm_pkg::EK_ENTER : lcvm_pkg::EK_NONE;
		end else begin
			b.kind = q[16] ? lcvm_pkg::EK_REJECT : lcvm_pkg::EK_LEAVE;
		end
		return b;
	endfunction

	logic adv;
	logic signed [15:0] x0_in, y0_in, x1_in, y1_in;
	logic signed [16:0] dx_in, dy_in, ww_in, wh_in;
	bnd_t bnd_in [4];

	logic               v_s1, ok_s1;
	logic signed [15:0] x0_s1, y0_s1;
	logic signed [16:0] dx_s1, dy_s1;
	bnd_t               bnd_s1 [4];

	logic               vld_sd [NS];
	logic               ok_sd  [NS];
	logic signed [15:0] x0_sd  [NS];
	logic signed [15:0] y0_sd  [NS];
	logic signed [16:0] dx_sd  [NS];
	logic signed [16:0] dy_sd  [NS];
	logic [1:0]         kind_sd [NS][4];
	logic [16:0]        den_sd  [NS][4];
	logic [16:0]        rem_sd  [NS][4];
	logic [F:0]         quo_sd  [NS][4];
	logic               sat_sd  [NS][4];

	logic [16:0] rem_nx [NS][4];
	logic [F:0]  quo_nx [NS][4];
	logic        sat_nx [NS][4];

	logic [TW-1:0] te_nx, tl_nx;
	logic          rej_nx;

	logic               v_sf, rej_sf;
	logic [TW-1:0]      te_sf, tl_sf;
	logic signed [15:0] x0_sf, y0_sf;
	logic signed [16:0] dx_sf, dy_sf;
	logic               vis_sf;

	assign adv      = !v_sf || !full;
	assign in_ready = adv;
	assign push     = v_sf && !full;

	assign x0_in = in_data[15:0];
	assign y0_in = in_data[31:16];
	assign x1_in = in_data[47:32];
	assign y1_in = in_data[63:48];

	always_comb begin
		dx_in = lcvm_pkg::sub17(x1_in, x0_in);
		dy_in = lcvm_pkg::sub17(y1_in, y0_in);
		ww_in = lcvm_pkg::sub17(cfg.win_x_max, cfg.win_x_min);
		wh_in = lcvm_pkg::sub17(cfg.win_y_max, cfg.win_y_min);
		bnd_in[0] = classify(-dx_in, lcvm_pkg::sub17(x0_in, cfg.win_x_min));
		bnd_in[1] = classify(dx_in, lcvm_pkg::sub17(cfg.win_x_max, x0_in));
		bnd_in[2] = classify(-dy_in, lcvm_pkg::sub17(y0_in, cfg.win_y_min));
		bnd_in[3] = classify(dy_in, lcvm_pkg::sub17(cfg.win_y_max, y0_in));
	end

	// one quotient bit per stage; the first stage also flags quotients of two or more
	always_comb begin
		logic [17:0] r2;
		logic        ge;
		r2 = '0;
		ge = 1'b0;
		for (int k = 0; k < 4; k++) begin
			sat_nx[0][k] = {1'b0, bnd_s1[k].num} >= {bnd_s1[k].den, 1'b0};
			if (bnd_s1[k].num >= bnd_s1[k].den) begin
				rem_nx[0][k] = bnd_s1[k].num - bnd_s1[k].den;
				quo_nx[0][k] = (F + 1)'(1);
			end else begin
				rem_nx[0][k] = bnd_s1[k].num;
				quo_nx[0][k] = '0;
			end
		end
		for (int j = 1; j < NS; j++) begin
			for (int k = 0; k < 4; k++) begin
				r2 = {rem_sd[j-1][k], 1'b0};
				ge = r2 >= {1'b0, den_sd[j-1][k]};
				rem_nx[j][k] = ge ? 17'(r2 - {1'b0, den_sd[j-1][k]}) : r2[16:0];
				quo_nx[j][k] = {quo_sd[j-1][k][F-1:0], ge};
				sat_nx[j][k] = sat_sd[j-1][k];
			end
		end
	end

	always_comb begin
		logic [TW-1:0] t;
		te_nx  = '0;
		tl_nx  = TONE;
		rej_nx = !ok_sd[NS-1];
		t      = '0;
		for (int k = 0; k < 4; k++) begin
			if (sat_sd[NS-1][k]) begin
				t = TSAT;
			end else if (kind_sd[NS-1][k] == lcvm_pkg::EK_ENTER) begin
				t = {1'b0, quo_sd[NS-1][k]} + TW'(rem_sd[NS-1][k] != '0);
			end else begin
				t = {1'b0, quo_sd[NS-1][k]};
			end
			case (kind_sd[NS-1][k])
				lcvm_pkg::EK_ENTER: if (t > te_nx) te_nx = t;
				lcvm_pkg::EK_LEAVE: if (t < tl_nx) tl_nx = t;
				lcvm_pkg::EK_REJECT: rej_nx = 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_sf <= 1'b0;
			for (int j = 0; j < NS; j++) begin
				vld_sd[j] <= 1'b0;
			end
		end else if (adv) begin
			v_s1      <= in_valid;
			vld_sd[0] <= v_s1;
			for (int j = 1; j < NS; j++) begin
				vld_sd[j] <= vld_sd[j-1];
			end
			v_sf <= vld_sd[NS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ok_s1  <= (ww_in > 0) && (wh_in > 0);
			x0_s1  <= x0_in;
			y0_s1  <= y0_in;
			dx_s1  <= dx_in;
			dy_s1  <= dy_in;
			bnd_s1 <= bnd_in;
			for (int j = 0; j < NS; j++) begin
				ok_sd[j] <= (j == 0) ? ok_s1 : ok_sd[(j == 0) ? 0 : j - 1];
				x0_sd[j] <= (j == 0) ? x0_s1 : x0_sd[(j == 0) ? 0 : j - 1];
				y0_sd[j] <= (j == 0) ? y0_s1 : y0_sd[(j == 0) ? 0 : j - 1];
				dx_sd[j] <= (j == 0) ? dx_s1 : dx_sd[(j == 0) ? 0 : j - 1];
				dy_sd[j] <= (j == 0) ? dy_s1 : dy_sd[(j == 0) ? 0 : j - 1];
				for (int k = 0; k < 4; k++) begin
					kind_sd[j][k] <= (j == 0) ? bnd_s1[k].kind : kind_sd[(j == 0) ? 0 : j - 1][k];
					den_sd[j][k]  <= (j == 0) ? bnd_s1[k].den : den_sd[(j == 0) ? 0 : j - 1][k];
					rem_sd[j][k]  <= rem_nx[j][k];
					quo_sd[j][k]  <= quo_nx[j][k];
					sat_sd[j][k]  <= sat_nx[j][k];
				end
			end
			te_sf  <= te_nx;
			tl_sf  <= tl_nx;
			rej_sf <= rej_nx;
			x0_sf  <= x0_sd[NS-1];
			y0_sf  <= y0_sd[NS-1];
			dx_sf  <= dx_sd[NS-1];
			dy_sf  <= dy_sd[NS-1];
		end
	end

	assign vis_sf    = !rej_sf && (te_sf <= tl_sf);
	assign push_data = {tl_sf[F:0], te_sf[F:0], dy_sf, dx_sf, y0_sf, x0_sf, vis_sf};

endmodule

`default_nettype wire

FILE: hdl/lcvm_back.sv
// Mapping back end: clipped endpoints, viewport scaling, pipelined rounding division.
// Depends on lcvm_pkg; takes words from lcvm_queue and holds the output register.
`timescale 1ns / 1ps
`default_nettype none

module lcvm_back #(
	parameter int FRACTION_BITS = 16,
	localparam int ItemW = 1 + 2 * 16 + 2 * 17 + 2 * (FRACTION_BITS + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  lcvm_pkg::cfg_t   cfg,
	input  logic             empty,
	output logic             pop,
	input  logic [ItemW-1:0] pop_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             out_vis,
	output logic [63:0]      out_data
);

	localparam int F    = FRACTION_BITS;
	localparam int AW   = F + 20;
	localparam int MW   = F + 19;
	localparam int PW   = 37;
	localparam int QB   = 18;
	localparam int NS   = QB + 1;
	localparam int TeLo = 67;
	localparam int TlLo = 68 + F;

	function automatic logic [15:0] sat16(input logic signed [19:0] v);
		if (v > 20'sd32767) begin
			return 16'h7fff;
		end else if (v < -20'sd32768) begin
			return 16'h8000;
		end
		return v[15:0];
	endfunction

	logic adv;
	logic signed [15:0] x0_h, y0_h;
	logic signed [16:0] dx_h, dy_h;
	logic [F:0]         te_h, tl_h;
	logic               vis_h;

	logic signed [16:0] ww_x, ww_y, vs_x, vs_y;
	logic [16:0]        ww_l [4];
	logic [16:0]        va_l [4];
	logic               vneg_l [4];
	logic signed [15:0] vmin_l [4];

	logic signed [16:0] base_nx [4];
	logic [F:0]         t_nx [4];
	logic signed [16:0] d_nx [4];

	logic                v_s1, v_s2, v_s3, v_s4, v_s5;
	logic                vis_s1, vis_s2, vis_s3, vis_s4, vis_s5;
	logic signed [16:0]  base_s1 [4];
	logic signed [F+18:0] prod_s1 [4];
	logic signed [AW-1:0] a_s2 [4];
	logic [MW-1:0]       mag_s3 [4];
	logic                neg_s3 [4], neg_s4 [4], neg_s5 [4];
	logic [35:0]         ph_s4 [4];
	logic [F+16:0]       pl_s4 [4];
	logic [PW-1:0]       pp_s5 [4];

	logic        vld_sd [NS];
	logic        vis_sd [NS];
	logic [16:0] rem_sd [NS][4];
	logic [17:0] low_sd [NS][4];
	logic [17:0] quo_sd [NS][4];
	logic        sat_sd [NS][4];
	logic        neg_sd [NS][4];

	logic [16:0] rem_nx [NS][4];
	logic [17:0] low_nx [NS][4];
	logic [17:0] quo_nx [NS][4];
	logic        sat_nx [NS][4];
	logic [PW-1:0] pp_nx [4];
	logic [63:0] coord_nx;

	logic        out_valid_q, vis_q;
	logic [63:0] out_data_q;

	assign adv = !out_valid_q || out_ready;
	assign pop = adv && !empty;

	assign vis_h = pop_data[0];
	assign x0_h  = pop_data[16:1];
	assign y0_h  = pop_data[32:17];
	assign dx_h  = pop_data[49:33];
	assign dy_h  = pop_data[66:50];
	assign te_h  = pop_data[TeLo+F:TeLo];
	assign tl_h  = pop_data[TlLo+F:TlLo];

	always_comb begin
		ww_x = lcvm_pkg::sub17(cfg.win_x_max, cfg.win_x_min);
		ww_y = lcvm_pkg::sub17(cfg.win_y_max, cfg.win_y_min);
		vs_x = lcvm_pkg::sub17(cfg.view_x_max, cfg.view_x_min);
		vs_y = lcvm_pkg::sub17(cfg.view_y_max, cfg.view_y_min);
		for (int l = 0; l < 4; l++) begin
			ww_l[l]   = (l % 2 == 0) ? ww_x : ww_y;
			vneg_l[l] = (l % 2 == 0) ? vs_x[16] : vs_y[16];
			if (l % 2 == 0) begin
				va_l[l] = vs_x[16] ? 17'(-vs_x) : vs_x;
			end else begin
				va_l[l] = vs_y[16] ? 17'(-vs_y) : vs_y;
			end
			vmin_l[l]  = (l % 2 == 0) ? cfg.view_x_min : cfg.view_y_min;
			base_nx[l] = (l % 2 == 0) ? lcvm_pkg::sub17(x0_h, cfg.win_x_min)
			                          : lcvm_pkg::sub17(y0_h, cfg.win_y_min);
			t_nx[l]    = (l < 2) ? te_h : tl_h;
			d_nx[l]    = (l % 2 == 0) ? dx_h : dy_h;
		end
	end

	// offset of the rounded quotient: (|a|*|v| + ww*2^(F-1)) >> F, then divide by ww
	always_comb begin
		logic [F+17:0] rs;
		rs = '0;
		for (int l = 0; l < 4; l++) begin
			rs = (F + 18)'(pl_s4[l]) + ((F + 18)'(ww_l[l]) << (F - 1));
			pp_nx[l] = PW'(ph_s4[l]) + PW'(rs[F+17:F]);
		end
	end

	always_comb begin
		logic [17:0] r2;
		logic        ge;
		r2 = '0;
		ge = 1'b0;
		for (int l = 0; l < 4; l++) begin
			sat_nx[0][l] = pp_s5[l] >= PW'({ww_l[l], 18'b0});
			rem_nx[0][l] = pp_s5[l][34:18];
			low_nx[0][l] = pp_s5[l][17:0];
			quo_nx[0][l] = '0;
		end
		for (int j = 1; j < NS; j++) begin
			for (int l = 0; l < 4; l++) begin
				r2 = {rem_sd[j-1][l], low_sd[j-1][l][17]};
				ge = r2 >= {1'b0, ww_l[l]};
				rem_nx[j][l] = ge ? 17'(r2 - {1'b0, ww_l[l]}) : r2[16:0];
				low_nx[j][l] = {low_sd[j-1][l][16:0], 1'b0};
				quo_nx[j][l] = {quo_sd[j-1][l][16:0], ge};
				sat_nx[j][l] = sat_sd[j-1][l];
			end
		end
	end

	always_comb begin
		logic [17:0]        m;
		logic signed [19:0] sm;
		logic signed [19:0] v;
		m  = '0;
		sm = '0;
		v  = '0;
		coord_nx = '0;
		for (int l = 0; l < 4; l++) begin
			m  = sat_sd[NS-1][l] ? '1 : quo_sd[NS-1][l];
			sm = neg_sd[NS-1][l] ? -$signed({2'b00, m}) : $signed({2'b00, m});
			v  = $signed({{4{vmin_l[l][15]}}, vmin_l[l]}) + sm;
			coord_nx[l*16 +: 16] = vis_sd[NS-1] ? sat16(v) : 16'h0000;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			out_valid_q <= 1'b0;
			for (int j = 0; j < NS; j++) begin
				vld_sd[j] <= 1'b0;
			end
		end else if (adv) begin
			v_s1      <= pop;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			v_s4      <= v_s3;
			v_s5      <= v_s4;
			vld_sd[0] <= v_s5;
			for (int j = 1; j < NS; j++) begin
				vld_sd[j] <= vld_sd[j-1];
			end
			out_valid_q <= vld_sd[NS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			vis_s1 <= vis_h;
			vis_s2 <= vis_s1;
			vis_s3 <= vis_s2;
			vis_s4 <= vis_s3;
			vis_s5 <= vis_s4;
			for (int l = 0; l < 4; l++) begin
				base_s1[l] <= base_nx[l];
				prod_s1[l] <= $signed({1'b0, t_nx[l]}) * d_nx[l];
				a_s2[l]    <= $signed({{3{base_s1[l][16]}}, base_s1[l], {F{1'b0}}})
				            + $signed({prod_s1[l][F+18], prod_s1[l]});
				mag_s3[l]  <= a_s2[l][AW-1] ? MW'(-a_s2[l]) : MW'(a_s2[l]);
				neg_s3[l]  <= a_s2[l][AW-1] ^ vneg_l[l];
				ph_s4[l]   <= mag_s3[l][MW-1:F] * va_l[l];
				pl_s4[l]   <= mag_s3[l][F-1:0] * va_l[l];
				neg_s4[l]  <= neg_s3[l];
				pp_s5[l]   <= pp_nx[l];
				neg_s5[l]  <= neg_s4[l];
			end
			for (int j = 0; j < NS; j++) begin
				vis_sd[j] <= (j == 0) ? vis_s5 : vis_sd[(j == 0) ? 0 : j - 1];
				for (int l = 0; l < 4; l++) begin
					rem_sd[j][l] <= rem_nx[j][l];
					low_sd[j][l] <= low_nx[j][l];
					quo_sd[j][l] <= quo_nx[j][l];
					sat_sd[j][l] <= sat_nx[j][l];
					neg_sd[j][l] <= (j == 0) ? neg_s5[l] : neg_sd[(j == 0) ? 0 : j - 1][l];
				end
			end
			vis_q      <= vis_sd[NS-1];
			out_data_q <= coord_nx;
		end
	end

	assign out_valid = out_valid_q;
	assign out_vis   = vis_q;
	assign out_data  = out_data_q;

	a_hidden_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !vis_q) |-> (out_data_q == '0))
		else $error("rejected segment carries coordinates");

endmodule

`default_nettype wire

FILE: bench/tb.sv
// Self-checking bench for line_clip_viewport_map: drives segments and register writes
// through the stream and config channels and checks each result against its own clip model.
// Depends on lcvm_pkg and the line_clip_viewport_map RTL.
`timescale 1ns / 1ps

module tb;

	localparam int FB = 16;
	localparam longint FIX_ONE = longint'(1) << FB;
	localparam logic [lcvm_pkg::CfgIdxW-1:0] REG_UNUSED   = 4'd15;
	localparam logic [lcvm_pkg::CfgIdxW-1:0] REG_PAST_END = 4'd8;

	typedef struct packed {
		logic        visible;
		logic [63:0] coords;
	} clip_word_t;

	logic clk, arst_n;
	logic s_axis_tvalid, s_axis_tready;
	logic [63:0] s_axis_tdata;
	logic m_axis_tvalid, m_axis_tready;
	logic [63:0] m_axis_tdata;
	logic m_axis_tuser;
	logic cfg_valid, cfg_ready;
	logic [3:0] cfg_index;
	logic [15:0] cfg_data;

	logic signed [15:0] regs [8];
	clip_word_t clip_expected_q [$];
	int mismatches = 0;
	int segs_sent = 0;
	int words_seen = 0;
	int visible_seen = 0;
	bit no_idle = 0;
	int stall_left = 0;
	bit out_taken;

	line_clip_viewport_map #(.FRACTION_BITS(FB)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("Timeout");
		$display("Some tests failed");
		$finish;
	end

	function automatic bit edge_clip(longint p, longint q, inout longint te, inout longint tl);
		longint n, d, t;
		if (p == 0) return q >= 0;
		if (p < 0) begin
			n = -q * FIX_ONE;
			d = -p;
			t = n / d;
			if ((n % d) != 0 && n > 0) t++;
			if (t > te) te = t;
		end else begin
			n = q * FIX_ONE;
			t = n / p;
			if ((n % p) != 0 && n < 0) t--;
			if (t < tl) tl = t;
		end
		return 1;
	endfunction

	function automatic logic [15:0] to_view(longint a, longint vspan, longint den, longint vmin);
		logic [127:0] ma, mv, d2, m;
		longint v;
		bit neg;
		ma = (a < 0) ? 128'(-a) : 128'(a);
		mv = (vspan < 0) ? 128'(-vspan) : 128'(vspan);
		d2 = 128'(den);
		neg = (a < 0) != (vspan < 0);
		m = (2 * ma * mv + d2) / (2 * d2);
		if (m > 128'h100000) m = 128'h100000;
		v = neg ? -longint'(m) : longint'(m);
		v += vmin;
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return v[15:0];
	endfunction

	function automatic clip_word_t predict_clip(logic [63:0] seg);
		clip_word_t r;
		longint x0, y0, x1, y1, dx, dy, xmn, ymn, ww, wh, te, tl;
		longint vxs, vys;
		bit ok;
		x0 = longint'($signed(seg[15:0]));
		y0 = longint'($signed(seg[31:16]));
		x1 = longint'($signed(seg[47:32]));
		y1 = longint'($signed(seg[63:48]));
		xmn = regs[lcvm_pkg::REG_WIN_X_MIN];
		ymn = regs[lcvm_pkg::REG_WIN_Y_MIN];
		ww = longint'(regs[lcvm_pkg::REG_WIN_X_MAX]) - xmn;
		wh = longint'(regs[lcvm_pkg::REG_WIN_Y_MAX]) - ymn;
		vxs = longint'(regs[lcvm_pkg::REG_VIEW_X_MAX]) - longint'(regs[lcvm_pkg::REG_VIEW_X_MIN]);
		vys = longint'(regs[lcvm_pkg::REG_VIEW_Y_MAX]) - longint'(regs[lcvm_pkg::REG_VIEW_Y_MIN]);
		dx = x1 - x0;
		dy = y1 - y0;
		te = 0;
		tl = FIX_ONE;
		ok = (ww > 0) && (wh > 0);
		if (ok) ok = edge_clip(-dx, x0 - xmn, te, tl);
		if (ok) ok = edge_clip(dx, longint'(regs[lcvm_pkg::REG_WIN_X_MAX]) - x0, te, tl);
		if (ok) ok = edge_clip(-dy, y0 - ymn, te, tl);
		if (ok) ok = edge_clip(dy, longint'(regs[lcvm_pkg::REG_WIN_Y_MAX]) - y0, te, tl);
		if (ok && te > tl) ok = 0;
		r = '0;
		if (ok) begin
			r.visible = 1;
			r.coords[15:0] = to_view((x0 - xmn) * FIX_ONE + te * dx, vxs, ww * FIX_ONE,
				regs[lcvm_pkg::REG_VIEW_X_MIN]);
			r.coords[31:16] = to_view((y0 - ymn) * FIX_ONE + te * dy, vys, wh * FIX_ONE,
				regs[lcvm_pkg::REG_VIEW_Y_MIN]);
			r.coords[47:32] = to_view((x0 - xmn) * FIX_ONE + tl * dx, vxs, ww * FIX_ONE,
				regs[lcvm_pkg::REG_VIEW_X_MIN]);
			r.coords[63:48] = to_view((y0 - ymn) * FIX_ONE + tl * dy, vys, wh * FIX_ONE,
				regs[lcvm_pkg::REG_VIEW_Y_MIN]);
		end
		return r;
	endfunction

	// result side: check at the falling edge, data is stable until the next rise
	always @(negedge clk) begin
		clip_word_t want;
		out_taken = m_axis_tvalid && m_axis_tready && arst_n;
		if (out_taken) begin
			words_seen++;
			if (m_axis_tuser) visible_seen++;
			if (clip_expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected word: visible=%0b data=%h", m_axis_tuser, m_axis_tdata);
			end else begin
				want = clip_expected_q.pop_front();
				if (want.visible !== m_axis_tuser || want.coords !== m_axis_tdata) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Mismatch: expected visible=%0b %h, got visible=%0b %h",
							want.visible, want.coords, m_axis_tuser, m_axis_tdata);
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_axis_tready <= (stall_left == 1);
		end else if (out_taken && !no_idle) begin
			int w;
			w = $urandom_range(0, 5);
			stall_left <= w;
			m_axis_tready <= (w == 0);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	task automatic wait_cfg_accept();
		bit hs;
		forever begin
			@(negedge clk);
			hs = cfg_ready;
			@(posedge clk);
			if (hs) break;
		end
	endtask

	task automatic cfg_write(logic [3:0] idx, logic [15:0] val);
		s_axis_tvalid <= 1'b0;
		while (clip_expected_q.size() != 0) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		wait_cfg_accept();
		cfg_valid <= 1'b0;
		if (idx <= lcvm_pkg::REG_VIEW_Y_MAX) regs[idx] = val;
		@(posedge clk);
	endtask

	task automatic set_window(int xmn, int ymn, int xmx, int ymx);
		cfg_write(lcvm_pkg::REG_WIN_X_MIN, xmn[15:0]);
		cfg_write(lcvm_pkg::REG_WIN_Y_MIN, ymn[15:0]);
		cfg_write(lcvm_pkg::REG_WIN_X_MAX, xmx[15:0]);
		cfg_write(lcvm_pkg::REG_WIN_Y_MAX, ymx[15:0]);
	endtask

	task automatic set_view(int xmn, int ymn, int xmx, int ymx);
		cfg_write(lcvm_pkg::REG_VIEW_X_MIN, xmn[15:0]);
		cfg_write(lcvm_pkg::REG_VIEW_Y_MIN, ymn[15:0]);
		cfg_write(lcvm_pkg::REG_VIEW_X_MAX, xmx[15:0]);
		cfg_write(lcvm_pkg::REG_VIEW_Y_MAX, ymx[15:0]);
	endtask

	task automatic send_segment(int x0, int y0, int x1, int y1);
		int gap;
		bit hs;
		logic [63:0] seg;
		seg = {y1[15:0], x1[15:0], y0[15:0], x0[15:0]};
		gap = no_idle ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= seg;
		forever begin
			@(negedge clk);
			hs = s_axis_tready;
			@(posedge clk);
			if (hs) break;
		end
		clip_expected_q.push_back(predict_clip(seg));
		segs_sent++;
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (clip_expected_q.size() != 0) @(posedge clk);
		repeat (FB + 40) @(posedge clk);
	endtask

	function automatic int near(int lo, int hi);
		int v;
		v = $urandom_range(0, 3) == 0 ? int'($signed(16'($urandom)))
			: lo + int'($urandom_range(0, 80)) - 40 + int'($urandom_range(0, 1)) * (hi - lo);
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return v;
	endfunction

	task automatic test_reset_window();
		send_segment(60, 60, 90, 90);
		send_segment(0, 75, 150, 75);
		send_segment(75, 0, 75, 150);
		send_segment(0, 0, 150, 150);
		send_segment(150, 0, 0, 150);
		send_segment(70, 70, 70, 70);
		send_segment(10, 10, 10, 10);
		send_segment(50, 50, 50, 50);
		send_segment(0, 40, 150, 40);
		send_segment(40, 60, 40, 90);
		send_segment(0, 101, 49, 150);
		send_segment(0, 0, 100, 50);
		send_segment(-32768, -32768, 32767, 32767);
		send_segment(32767, -32768, -32768, 32767);
		send_segment(-32768, 75, 32767, 75);
		send_segment(32767, 32767, 32767, 32767);
		send_segment(100, 100, 0, 150);
		drain();
	endtask

	task automatic test_odd_windows();
		set_window(10, 10, 10, 80);
		send_segment(0, 20, 30, 20);
		send_segment(10, 20, 10, 20);
		set_window(10, 90, 80, 20);
		send_segment(0, 50, 90, 50);
		set_window(-32768, -32768, 32767, 32767);
		set_view(-32768, 32767, 32767, -32768);
		send_segment(-32768, -32768, 32767, 32767);
		send_segment(0, 0, -1, 1);
		set_window(0, 0, 1, 1);
		set_view(-32768, -32768, 32767, 32767);
		send_segment(0, 0, 1, 1);
		send_segment(-5, 1, 5, 0);
		cfg_write(REG_UNUSED, 16'h0);
		cfg_write(REG_PAST_END, 16'hffff);
		send_segment(1, 0, 0, 1);
		drain();
	endtask

	task automatic test_random(int phases, int per_phase);
		int cx, cy, w, h, k;
		for (int p = 0; p < phases; p++) begin
			no_idle = (p % 4 == 3);
			case ($urandom_range(0, 3))
				0: begin
					cx = int'($signed(16'($urandom)));
					cy = int'($signed(16'($urandom)));
					w = int'($signed(16'($urandom)));
					h = int'($signed(16'($urandom)));
					set_window(cx, cy, w, h);
				end
				1: set_window(-32768, -32768, 32767, 32767);
				default: begin
					w = $urandom_range(1, 400);
					h = $urandom_range(1, 400);
					cx = $urandom_range(0, 2000) - 1000;
					cy = $urandom_range(0, 2000) - 1000;
					set_window(cx, cy, cx + w, cy + h);
				end
			endcase
			if ($urandom_range(0, 2) == 0)
				set_view(int'($signed(16'($urandom))), int'($signed(16'($urandom))),
					int'($signed(16'($urandom))), int'($signed(16'($urandom))));
			else
				set_view(-300, 100, 500, -200);
			for (k = 0; k < per_phase; k++) begin
				if ($urandom_range(0, 4) == 0)
					send_segment(int'($signed(16'($urandom))), int'($signed(16'($urandom))),
						int'($signed(16'($urandom))), int'($signed(16'($urandom))));
				else
					send_segment(near(regs[lcvm_pkg::REG_WIN_X_MIN], regs[lcvm_pkg::REG_WIN_X_MAX]),
						near(regs[lcvm_pkg::REG_WIN_Y_MIN], regs[lcvm_pkg::REG_WIN_Y_MAX]),
						near(regs[lcvm_pkg::REG_WIN_X_MIN], regs[lcvm_pkg::REG_WIN_X_MAX]),
						near(regs[lcvm_pkg::REG_WIN_Y_MIN], regs[lcvm_pkg::REG_WIN_Y_MAX]));
			end
			drain();
		end
		no_idle = 0;
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		regs[lcvm_pkg::REG_WIN_X_MIN] = lcvm_pkg::RST_WIN_MIN;
		regs[lcvm_pkg::REG_WIN_Y_MIN] = lcvm_pkg::RST_WIN_MIN;
		regs[lcvm_pkg::REG_WIN_X_MAX] = lcvm_pkg::RST_WIN_MAX;
		regs[lcvm_pkg::REG_WIN_Y_MAX] = lcvm_pkg::RST_WIN_MAX;
		regs[lcvm_pkg::REG_VIEW_X_MIN] = lcvm_pkg::RST_VIEW_MIN;
		regs[lcvm_pkg::REG_VIEW_Y_MIN] = lcvm_pkg::RST_VIEW_MIN;
		regs[lcvm_pkg::REG_VIEW_X_MAX] = lcvm_pkg::RST_VIEW_MAX;
		regs[lcvm_pkg::REG_VIEW_Y_MAX] = lcvm_pkg::RST_VIEW_MAX;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_window();
		test_odd_windows();
		test_random(12, 52);

		if (clip_expected_q.size() != 0) begin
			mismatches += clip_expected_q.size();
			$display("%0d expected words never arrived", clip_expected_q.size());
		end
		$display("Sent %0d segments over reset, degenerate and random windows;", segs_sent);
		$display("checked %0d result words, %0d of them visible.", words_seen, visible_seen);
		if (mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

FILE: files.f
hdl/lcvm_pkg.sv
hdl/lcvm_queue.sv
hdl/lcvm_front.sv
hdl/lcvm_back.sv
hdl/line_clip_viewport_map.sv
bench/tb.sv
